>>> rtl/psh_pkg.sv
// Package: shared constants, types and codes for the ready-set scheduler.
package psh_pkg;
	localparam int MaxProcs  = 16;
	localparam int NumLevels = 3;
	localparam int IdW       = $clog2(MaxProcs);
	localparam int CntW      = $clog2(MaxProcs + 1);

	typedef enum logic [1:0] {
		OP_ADMIT   = 2'd0,
		OP_REQUEUE = 2'd1,
		OP_PICK    = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_FCFS = 2'd0,
		MODE_RR   = 2'd1,
		MODE_HRRN = 2'd2,
		MODE_MLFQ = 2'd3
	} mode_t;

	localparam logic [0:0] REG_POLICY  = 1'd0;
	localparam logic [0:0] REG_QUANTUM = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_CMP,
		ST_DONE
	} state_t;

	// Candidate fields presented to the compare unit.
	typedef struct packed {
		logic [31:0] age;
		logic [31:0] wait_t;
		logic [11:0] len;
		logic [1:0]  lvl;
	} cand_t;
endpackage

>>> rtl/psh_cmp_unit.sv
// Shared compare unit: cross-multiply ratio, level or age compare, with registered products.
module psh_cmp_unit
	import psh_pkg::*;
(
	input  logic        clk,
	input  logic        start,
	input  mode_t       mode,
	input  cand_t       cand,
	input  cand_t       best,
	output logic        take
);
	logic [12:0] la, lb;
	logic [45:0] pa_s1, pb_s1;
	logic        older_s1, lvl_lt_s1, lvl_eq_s1;
	mode_t       mode_s1;

	assign la = (cand.len == 12'd0) ? 13'd1 : {1'b0, cand.len};
	assign lb = (best.len == 12'd0) ? 13'd1 : {1'b0, best.len};

	// Multiply (wait + len) by the other length, register before compare.
	always_ff @(posedge clk) begin
		if (start) begin
			pa_s1     <= ({13'd0, 1'b0, cand.wait_t} + {33'd0, la}) * {33'd0, lb};
			pb_s1     <= ({13'd0, 1'b0, best.wait_t} + {33'd0, lb}) * {33'd0, la};
			older_s1  <= cand.age > best.age;
			lvl_lt_s1 <= cand.lvl < best.lvl;
			lvl_eq_s1 <= cand.lvl == best.lvl;
			mode_s1   <= mode;
		end
	end

	always_comb begin
		case (mode_s1)
			MODE_HRRN: take = (pa_s1 > pb_s1) || (!(pb_s1 > pa_s1) && older_s1);
			MODE_MLFQ: take = lvl_lt_s1 || (lvl_eq_s1 && older_s1);
			default:   take = older_s1;
		endcase
	end
endmodule

>>> rtl/process_scheduler_hrrn_mlfq_rr.sv
// Top level: ready-set scheduler with FCFS, RR, HRRN and MLFQ selection.
// Admit, requeue and unused opcodes give their result in the cycle after accept.
// A pick walks all 16 slots in ST_SCAN with one shared compare unit; each ready slot after
// the first also passes through ST_MUL and ST_CMP, and the finished scan then goes to ST_DONE.
// One item at a time; in_stall is high from accept until the result is taken.
// Reset clears ready flags, levels, stamp counter and state, sets FCFS and quantum 1; slot data is unset.
module process_scheduler_hrrn_mlfq_rr
	import psh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  proc_id,
	input  logic [11:0] length,
	input  logic [12:0] ran_steps,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [3:0]  chosen_id,
	output logic [12:0] budget
);
	mode_t        mode_q;
	logic [7:0]   quantum_q;
	logic [MaxProcs-1:0] ready_q;
	logic [1:0]   level_q [MaxProcs];
	logic [11:0]  len_q   [MaxProcs];
	logic [31:0]  rtime_q [MaxProcs];
	logic [31:0]  stamp_q [MaxProcs];
	logic [31:0]  counter_q;

	state_t       state_q, state_d;
	logic [31:0]  now_q;
	logic [CntW-1:0] idx_q;
	logic         have_q;
	logic [IdW-1:0] best_q;
	logic         found_q;
	logic [IdW-1:0] id_q;
	logic [12:0]  budget_q;

	logic         accept, take, start;
	logic [IdW-1:0] idx;
	cand_t        cand, best;

	assign accept = in_valid && !in_stall;
	assign idx    = idx_q[IdW-1:0];
	assign in_stall = (state_q != ST_IDLE);

	assign cand = '{age: counter_q - stamp_q[idx], wait_t: now_q - rtime_q[idx],
		len: len_q[idx], lvl: level_q[idx]};
	assign best = '{age: counter_q - stamp_q[best_q], wait_t: now_q - rtime_q[best_q],
		len: len_q[best_q], lvl: level_q[best_q]};
	assign start = (state_q == ST_SCAN) && ready_q[idx] && have_q
		&& (idx_q < CntW'(MaxProcs));

	psh_cmp_unit u_cmp (
		.clk   (clk),
		.start (start),
		.mode  (mode_q),
		.cand  (cand),
		.best  (best),
		.take  (take)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = (opcode_t'(opcode) == OP_PICK) ? ST_SCAN : ST_DONE;
			ST_SCAN: begin
				if (idx_q == CntW'(MaxProcs)) state_d = ST_DONE;
				else if (start) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_CMP;
			ST_CMP:  state_d = ST_SCAN;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		out_valid = (state_q == ST_DONE);
		found     = found_q;
		chosen_id = id_q;
		budget    = budget_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_FCFS;
			quantum_q <= 8'd1;
			ready_q   <= '0;
			counter_q <= '0;
			found_q   <= 1'b0;
			have_q    <= 1'b0;
			idx_q     <= '0;
			for (int i = 0; i < MaxProcs; i++) level_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_POLICY) mode_q <= mode_t'(cfg_data[1:0]);
				else quantum_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: if (accept) begin
					found_q <= 1'b0;
					have_q  <= 1'b0;
					idx_q   <= '0;
					// Admit and requeue complete here.
					if (opcode_t'(opcode) == OP_ADMIT || opcode_t'(opcode) == OP_REQUEUE) begin
						if (opcode_t'(opcode) == OP_ADMIT) level_q[proc_id] <= '0;
						else if (mode_q == MODE_MLFQ
							&& ran_steps >= (13'd1 << level_q[proc_id])
							&& level_q[proc_id] < 2'(NumLevels - 1))
							level_q[proc_id] <= level_q[proc_id] + 2'd1;
						ready_q[proc_id] <= 1'b1;
						counter_q        <= counter_q + 32'd1;
					end
				end
				ST_SCAN: begin
					if (idx_q == CntW'(MaxProcs)) begin
						if (have_q) begin
							ready_q[best_q] <= 1'b0;
							found_q <= 1'b1;
						end
					end else begin
						if (ready_q[idx] && !have_q) have_q <= 1'b1;
						// Hold the index while the compare unit works.
						if (!start) idx_q <= idx_q + CntW'(1);
					end
				end
				ST_CMP: idx_q <= idx_q + CntW'(1);
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			now_q <= now;
			id_q  <= '0;
			budget_q <= '0;
			if (opcode_t'(opcode) == OP_ADMIT) len_q[proc_id] <= length;
			if (opcode_t'(opcode) == OP_ADMIT || opcode_t'(opcode) == OP_REQUEUE) begin
				rtime_q[proc_id] <= now;
				stamp_q[proc_id] <= counter_q;
			end
		end
		if (state_q == ST_SCAN && idx_q != CntW'(MaxProcs) && ready_q[idx] && !have_q)
			best_q <= idx;
		if (state_q == ST_CMP && take) best_q <= idx;
		if (state_q == ST_SCAN && idx_q == CntW'(MaxProcs) && have_q) begin
			id_q <= best_q;
			case (mode_q)
				MODE_RR:   budget_q <= {5'd0, quantum_q};
				MODE_MLFQ: budget_q <= 13'd1 << level_q[best_q];
				default:   budget_q <= {1'b0, len_q[best_q]} + 13'd1;
			endcase
		end
	end
endmodule

>>> rtl/psh_checker.sv
// Checker: port-level properties of the scheduler, bound to the top level.
module psh_sva
	import psh_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [3:0]  chosen_id,
	input logic [12:0] budget
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(budget))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> chosen_id == 4'd0 && budget == 13'd0)
		else $error("empty result carries data");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first one finished");
endmodule

bind process_scheduler_hrrn_mlfq_rr psh_sva u_chk (.*);

>>> dv/psh_checker.sv
// Checker: watches the scheduler channels, predicts each result and compares it.
`timescale 1ns / 100ps
module psh_checker
	import psh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  proc_id,
	input  logic [11:0] length,
	input  logic [12:0] ran_steps,
	input  logic [31:0] now,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        found,
	input  logic [3:0]  chosen_id,
	input  logic [12:0] budget,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic        found;
		logic [3:0]  id;
		logic [12:0] budget;
	} grant_t;

	grant_t      grants_due[$];
	mode_t       mode;
	logic [7:0]  quantum;
	logic        ready  [MaxProcs];
	logic [1:0]  level  [MaxProcs];
	logic [11:0] plen   [MaxProcs];
	logic [31:0] rtime  [MaxProcs];
	logic [31:0] stamp  [MaxProcs];
	logic [31:0] stamp_cnt;

	assign pending = grants_due.size();

	function automatic logic older(int a, int b);
		return (stamp_cnt - stamp[a]) > (stamp_cnt - stamp[b]);
	endfunction

	function automatic logic ratio_gt(int a, int b, logic [31:0] t);
		logic [63:0] la, lb, wa, wb;
		logic [31:0] da, db;
		la = (plen[a] == 0) ? 64'd1 : 64'(plen[a]);
		lb = (plen[b] == 0) ? 64'd1 : 64'(plen[b]);
		// wait wraps at 32 bits before it is widened
		da = t - rtime[a];
		db = t - rtime[b];
		wa = 64'(da);
		wb = 64'(db);
		return (wa + la) * lb > (wb + lb) * la;
	endfunction

	function automatic int best_slot(logic [31:0] t);
		int  best;
		logic take;
		best = -1;
		for (int i = 0; i < MaxProcs; i++) begin
			if (!ready[i]) continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			if (mode == MODE_HRRN)
				take = ratio_gt(i, best, t) || (!ratio_gt(best, i, t) && older(i, best));
			else if (mode == MODE_MLFQ)
				take = level[i] < level[best] || (level[i] == level[best] && older(i, best));
			else
				take = older(i, best);
			if (take) best = i;
		end
		return best;
	endfunction

	task automatic schedule_item();
		grant_t g;
		int     s;
		g = '0;
		case (opcode_t'(opcode))
			OP_ADMIT: begin
				level[proc_id] = 0;
				plen[proc_id]  = length;
				ready[proc_id] = 1'b1;
				rtime[proc_id] = now;
				stamp[proc_id] = stamp_cnt;
				stamp_cnt++;
			end
			OP_REQUEUE: begin
				// demote only when the whole quantum of the level was used
				if (mode == MODE_MLFQ && 32'(ran_steps) >= (32'd1 << level[proc_id]) &&
					level[proc_id] < NumLevels - 1)
					level[proc_id]++;
				ready[proc_id] = 1'b1;
				rtime[proc_id] = now;
				stamp[proc_id] = stamp_cnt;
				stamp_cnt++;
			end
			OP_PICK: begin
				s = best_slot(now);
				if (s >= 0) begin
					ready[s] = 1'b0;
					g.found  = 1'b1;
					g.id     = s[3:0];
					if (mode == MODE_RR)        g.budget = 13'(quantum);
					else if (mode == MODE_MLFQ) g.budget = 13'd1 << level[s];
					else                        g.budget = 13'(plen[s]) + 13'd1;
				end
			end
			default: ;
		endcase
		grants_due.push_back(g);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t e;
		if (!arst_n) begin
			mode       <= MODE_FCFS;
			quantum    <= 8'd1;
			stamp_cnt  = '0;
			fail_count <= 0;
			grants_due.delete();
			for (int i = 0; i < MaxProcs; i++) begin
				ready[i] = 1'b0;
				level[i] = '0;
				plen[i]  = '0;
				rtime[i] = '0;
				stamp[i] = '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POLICY) mode <= mode_t'(cfg_data[1:0]);
				else                         quantum <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					$display("%0t: unexpected result found=%0d id=%0d budget=%0d",
						$time, found, chosen_id, budget);
					fail_count <= fail_count + 1;
				end else begin
					e = grants_due.pop_front();
					if (e.found !== found || e.id !== chosen_id || e.budget !== budget) begin
						$display("%0t: expected found=%0d id=%0d budget=%0d, got %0d %0d %0d",
							$time, e.found, e.id, e.budget, found, chosen_id, budget);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) schedule_item();
		end
	end
endmodule

>>> dv/tb_top.sv
// Testbench top: drives the scheduler with directed and random items and reports the verdict.
`timescale 1ns / 100ps
module tb_top
	import psh_pkg::*;
();

	localparam int IdleLimit = 3000;
	localparam int Phases    = 8;
	localparam int PerPhase  = 170;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = '0;
	logic [3:0]  proc_id = '0;
	logic [11:0] length = '0;
	logic [12:0] ran_steps = '0;
	logic [31:0] now = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [3:0]  chosen_id;
	logic [12:0] budget;
	int          fail_count, pending;

	// Sender and receiver controls
	logic        quiet = 1'b0;
	logic        hold_req = 1'b0;
	logic [15:0] admitted = '0;
	logic [31:0] tick = '0;
	int          idle_cycles = 0;

	process_scheduler_hrrn_mlfq_rr dut (.*);

	psh_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort when no item moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req  = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one item and hold it until accepted; ends on the accepting edge.
	task automatic send(opcode_t op, logic [3:0] pid, logic [11:0] len,
			logic [12:0] ran, logic [31:0] t);
		logic taken;
		in_valid  <= 1'b1;
		opcode    <= op;
		proc_id   <= pid;
		length    <= len;
		ran_steps <= ran;
		now       <= t;
		if (op == OP_ADMIT) admitted[pid] = 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop valid for a burst of random length.
	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 10)) @(posedge clk);
	endtask

	// Write both registers once every result has drained.
	task automatic set_config(mode_t m, logic [7:0] q);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POLICY;
		cfg_data  <= 8'(m);
		@(posedge clk);
		cfg_index <= REG_QUANTUM;
		cfg_data  <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random item: mostly admit, requeue and pick on admitted slots, with some noise.
	task automatic random_item();
		int          r;
		logic [3:0]  pid;
		logic [11:0] len;
		logic [12:0] ran;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0) tick = $urandom;
		else tick = tick + $urandom_range(0, 300);
		pid = $urandom_range(0, 15);
		len = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 1) * 12'hFFF) : 12'($urandom);
		ran = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8)) : 13'($urandom);
		if (r < 35 || admitted == 0) send(OP_ADMIT, pid, len, ran, tick);
		else if (r < 60) begin
			// requeue only slots that hold a written length
			while (!admitted[pid]) pid = $urandom_range(0, 15);
			send(OP_REQUEUE, pid, len, ran, tick);
		end else if (r < 95) send(OP_PICK, pid, len, ran, tick);
		else send(OP_NONE, pid, len, ran, tick);
	endtask

	initial begin
		mode_t      m;
		logic [7:0] q;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pick, extremes, overwrite, unused opcode, requeue of a ready slot.
		send(OP_PICK,    4'd0,  12'd0,    13'd0,    32'd0);
		send(OP_ADMIT,   4'd0,  12'd0,    13'd0,    32'd0);
		send(OP_ADMIT,   4'd15, 12'hFFF,  13'h1FFF, 32'hFFFF_FFFF);
		send(OP_ADMIT,   4'd0,  12'd7,    13'd0,    32'd5);
		send(OP_REQUEUE, 4'd0,  12'd0,    13'd4096, 32'd6);
		send(OP_NONE,    4'd3,  12'hFFF,  13'h1FFF, 32'hFFFF_FFFF);
		send(OP_PICK,    4'd0,  12'd0,    13'd0,    32'd7);
		send(OP_PICK,    4'd0,  12'd0,    13'd0,    32'd8);
		send(OP_PICK,    4'd0,  12'd0,    13'd0,    32'd9);

		// Ratio with zero length, wrapped wait and a tie
		set_config(MODE_HRRN, 8'd1);
		send(OP_ADMIT, 4'd1, 12'd0,   13'd0, 32'hFFFF_FFF0);
		send(OP_ADMIT, 4'd2, 12'd4,   13'd0, 32'd10);
		send(OP_ADMIT, 4'd3, 12'd4,   13'd0, 32'd10);
		send(OP_ADMIT, 4'd4, 12'hFFF, 13'd0, 32'd0);
		repeat (4) send(OP_PICK, 4'd0, 12'd0, 13'd0, 32'd20);

		// Demotion through every level and its saturation
		set_config(MODE_MLFQ, 8'd255);
		send(OP_ADMIT,   4'd5, 12'd9, 13'd0,    32'd30);
		send(OP_ADMIT,   4'd6, 12'd9, 13'd0,    32'd31);
		send(OP_REQUEUE, 4'd5, 12'd0, 13'd1,    32'd32);
		send(OP_REQUEUE, 4'd5, 12'd0, 13'd2,    32'd33);
		send(OP_REQUEUE, 4'd5, 12'd0, 13'h1FFF, 32'd34);
		send(OP_REQUEUE, 4'd6, 12'd0, 13'd0,    32'd35);
		repeat (2) send(OP_PICK, 4'd0, 12'd0, 13'd0, 32'd36);

		// Zero quantum passes through as written
		set_config(MODE_RR, 8'd0);
		send(OP_ADMIT, 4'd7, 12'd1, 13'd0, 32'd40);
		send(OP_PICK,  4'd0, 12'd0, 13'd0, 32'd41);

		for (int p = 0; p < Phases; p++) begin
			m = mode_t'(p % 4);
			q = (p == 1) ? 8'd255 : (p == 5) ? 8'd1 : 8'($urandom_range(1, 255));
			set_config(m, q);
			if (p == 2) hold_req = 1'b1;
			if (p == Phases - 1) quiet = 1'b1;
			for (int k = 0; k < PerPhase; k++) begin
				random_item();
				if (!quiet && $urandom_range(0, 5) == 0) gap();
			end
		end
		set_config(MODE_FCFS, 8'd1);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

>>> process_scheduler_hrrn_mlfq_rr.f
rtl/psh_pkg.sv
rtl/psh_cmp_unit.sv
rtl/process_scheduler_hrrn_mlfq_rr.sv
rtl/psh_checker.sv
dv/psh_checker.sv
dv/tb_top.sv
